@@ hw/rtl/luhn_card_number_check_defines.svh @@
// Assertion macros used by the card number check controller.
`ifndef LUHN_CARD_NUMBER_CHECK_DEFINES_SVH
`define LUHN_CARD_NUMBER_CHECK_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LCC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("card check assertion failed");
// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("card check assertion failed");
`else
`define LCC_ASSERT_NOW(lbl, ante, cons)
`define LCC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ hw/rtl/lcc_pkg.sv @@
// Types, constants and helper functions of the card number check.
package lcc_pkg;

    localparam int NUM_W       = 64;
    localparam int BCD_DIGITS  = 20;
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int BITS_PER_CYC = 4;
    localparam int CONV_STEPS  = NUM_W / BITS_PER_CYC;
    localparam int STEP_W      = $clog2(CONV_STEPS);

    localparam int STATUS_W = 3;
    localparam int SUM_W    = 8;
    localparam int COUNT_W  = 5;
    localparam int PAIR_W   = 7;

    localparam logic [STATUS_W-1:0] STATUS_SUM_FAIL   = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_LENGTH = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_PAIR_34_37 = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_PAIR_51_55 = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_LEAD_FOUR  = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_UNKNOWN    = 3'd5;

    localparam logic [COUNT_W-1:0] LEN_13 = 5'd13;
    localparam logic [COUNT_W-1:0] LEN_15 = 5'd15;
    localparam logic [COUNT_W-1:0] LEN_16 = 5'd16;

    localparam logic [PAIR_W-1:0] PAIR_34 = 7'd34;
    localparam logic [PAIR_W-1:0] PAIR_37 = 7'd37;
    localparam logic [PAIR_W-1:0] PAIR_51 = 7'd51;
    localparam logic [PAIR_W-1:0] PAIR_55 = 7'd55;
    localparam logic [3:0]        LEAD_FOUR = 4'd4;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic conv;
        logic peel;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic rest_zero;
    } t_dp_sts;

    // Digit sum of twice a decimal digit.
    function automatic logic [3:0] dbl_digit_sum(input logic [3:0] d);
        logic [3:0] r;
        case (d)
            4'd0:    r = 4'd0;
            4'd1:    r = 4'd2;
            4'd2:    r = 4'd4;
            4'd3:    r = 4'd6;
            4'd4:    r = 4'd8;
            4'd5:    r = 4'd1;
            4'd6:    r = 4'd3;
            4'd7:    r = 4'd5;
            4'd8:    r = 4'd7;
            4'd9:    r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/lcc_datapath.sv @@
// Datapath: binary to BCD conversion, digit peeling, Luhn sum and result register.
module lcc_datapath
    import lcc_pkg::*;
(
    input  logic                i_clk,
    input  t_dp_cmd             i_cmd,
    input  logic [NUM_W-1:0]    i_card_number,
    output t_dp_sts             o_sts,
    output logic [STATUS_W-1:0] o_status,
    output logic [SUM_W-1:0]    o_luhn_sum,
    output logic [COUNT_W-1:0]  o_digit_count,
    output logic [PAIR_W-1:0]   o_leading_pair
);

    logic [NUM_W-1:0]    r_bin,    n_bin;
    logic [BCD_W-1:0]    r_bcd,    n_bcd;
    logic [SUM_W-1:0]    r_sum,    n_sum;
    logic [3:0]          r_mod,    n_mod;
    logic [COUNT_W-1:0]  r_count,  n_count;
    logic [3:0]          r_top,    n_top;
    logic [3:0]          r_second, n_second;

    logic [STATUS_W-1:0] r_status;
    logic [SUM_W-1:0]    r_out_sum;
    logic [COUNT_W-1:0]  r_out_count;
    logic [PAIR_W-1:0]   r_out_pair;

    logic [BCD_W-1:0]    dab_bcd;
    logic [NUM_W-1:0]    dab_bin;
    logic [3:0]          digit;
    logic [COUNT_W-1:0]  count_inc;
    logic [3:0]          contrib;
    logic [4:0]          mod_raw;
    logic [PAIR_W-1:0]   pair;
    logic                len_ok;
    logic [STATUS_W-1:0] status;

    // Shift in four input bits, add-3 correcting each BCD digit before each shift.
    always_comb begin
        dab_bcd = r_bcd;
        dab_bin = r_bin;
        for (int s = 0; s < BITS_PER_CYC; s++) begin
            for (int k = 0; k < BCD_DIGITS; k++) begin
                if (dab_bcd[4*k +: 4] >= 4'd5) begin
                    dab_bcd[4*k +: 4] = dab_bcd[4*k +: 4] + 4'd3;
                end
            end
            dab_bcd = {dab_bcd[BCD_W-2:0], dab_bin[NUM_W-1]};
            dab_bin = {dab_bin[NUM_W-2:0], 1'b0};
        end
    end

    // Peel the lowest BCD digit.
    always_comb begin
        digit     = r_bcd[3:0];
        count_inc = r_count + 1'b1;
        contrib   = count_inc[0] ? digit : dbl_digit_sum(digit);
        mod_raw   = {1'b0, r_mod} + {1'b0, contrib};
        if (mod_raw >= 5'd10) begin
            mod_raw = mod_raw - 5'd10;
        end
    end

    always_comb begin
        n_bin    = r_bin;
        n_bcd    = r_bcd;
        n_sum    = r_sum;
        n_mod    = r_mod;
        n_count  = r_count;
        n_top    = r_top;
        n_second = r_second;
        if (i_cmd.load) begin
            n_bin    = i_card_number;
            n_bcd    = '0;
            n_sum    = '0;
            n_mod    = '0;
            n_count  = '0;
            n_top    = '0;
            n_second = '0;
        end else if (i_cmd.conv) begin
            n_bin = dab_bin;
            n_bcd = dab_bcd;
        end else if (i_cmd.peel) begin
            n_bcd    = {4'd0, r_bcd[BCD_W-1:4]};
            n_sum    = r_sum + {4'd0, contrib};
            n_mod    = mod_raw[3:0];
            n_count  = count_inc;
            n_second = r_top;
            n_top    = digit;
        end
    end

    // Classify the finished number.
    always_comb begin
        pair   = ({3'd0, r_top} << 3) + ({3'd0, r_top} << 1) + {3'd0, r_second};
        len_ok = (r_count == LEN_13) || (r_count == LEN_15) || (r_count == LEN_16);
        if (r_mod != 4'd0) begin
            status = STATUS_SUM_FAIL;
        end else if (!len_ok) begin
            status = STATUS_BAD_LENGTH;
        end else if ((pair == PAIR_34) || (pair == PAIR_37)) begin
            status = STATUS_PAIR_34_37;
        end else if ((pair >= PAIR_51) && (pair <= PAIR_55)) begin
            status = STATUS_PAIR_51_55;
        end else if (r_top == LEAD_FOUR) begin
            status = STATUS_LEAD_FOUR;
        end else begin
            status = STATUS_UNKNOWN;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin    <= n_bin;
        r_bcd    <= n_bcd;
        r_sum    <= n_sum;
        r_mod    <= n_mod;
        r_count  <= n_count;
        r_top    <= n_top;
        r_second <= n_second;
        if (i_cmd.emit) begin
            r_status    <= status;
            r_out_sum   <= r_sum;
            r_out_count <= r_count;
            r_out_pair  <= (status >= STATUS_PAIR_34_37) ? pair : '0;
        end
    end

    assign o_sts.rest_zero = (r_bcd == '0);
    assign o_status        = r_status;
    assign o_luhn_sum      = r_out_sum;
    assign o_digit_count   = r_out_count;
    assign o_leading_pair  = r_out_pair;

endmodule

@@ hw/rtl/lcc_ctrl.sv @@
// Controller: sequences conversion and digit peeling, owns both handshakes.
`include "luhn_card_number_check_defines.svh"

module lcc_ctrl
    import lcc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_card_valid,
    output logic    o_card_ready,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_PEEL = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CONV_STEPS - 1);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step,  n_step;
    logic              r_out_valid, n_out_valid;
    logic              out_free;

    assign out_free = !r_out_valid || i_res_ready;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_card_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.conv = 1'b1;
                n_step     = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = S_PEEL;
                end
            end
            S_PEEL: begin
                if (i_sts.rest_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.peel = 1'b1;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_res_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_card_ready = (r_state == S_IDLE);
    assign o_res_valid  = r_out_valid;

    `LCC_ASSERT_NOW(a_emit_into_free, o_cmd.emit, !r_out_valid || i_res_ready)
    `LCC_ASSERT_NEXT(a_accept_starts_conv, i_card_valid && o_card_ready, r_state == S_CONV)
    `LCC_ASSERT_NOW(a_no_peel_when_empty, o_cmd.peel, !i_sts.rest_zero)
    `LCC_ASSERT_NEXT(a_conv_ends_in_peel, (r_state == S_CONV) && (r_step == LAST_STEP), r_state == S_PEEL)

endmodule

@@ hw/rtl/luhn_card_number_check.sv @@
// Top level of the Luhn mod-10 card number check.
// One 64-bit binary card number is taken per beat on the input channel and
// one result beat comes back for it: the Luhn sum, the decimal digit count,
// the two leading digits (zero on checksum fail or bad length) and a status
// code (checksum fail, bad length, prefix 34/37, prefix 51-55, leading 4,
// unknown), checked in that order. The number is first turned into 20 BCD
// digits by a shift-and-add-3 converter that takes four input bits per
// cycle, then one digit is peeled off per cycle from the right until no
// nonzero digits remain (the number has 0 to 20 digits), then the
// controller sees that no digits remain and, once the output register is
// free, classifies the number and loads that register. The input is ready
// again in the same cycle as the loaded result first shows as valid.
// One item is in work at a time. The result sits in an output register,
// so the next input beat is taken while an earlier result still waits
// for the downstream ready. Input zero has no digits and reports bad length.
// Reset is synchronous and active low.
module luhn_card_number_check
    import lcc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input channel
    input  logic                i_card_valid,
    output logic                o_card_ready,
    input  logic [NUM_W-1:0]    i_card_number,
    // Result channel
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [SUM_W-1:0]    o_luhn_sum,
    output logic [COUNT_W-1:0]  o_digit_count,
    output logic [PAIR_W-1:0]   o_leading_pair
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequencer: load, convert, peel, emit.
    lcc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_card_valid (i_card_valid),
        .o_card_ready (o_card_ready),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .i_sts        (dp_sts),
        .o_cmd        (dp_cmd)
    );

    // Converter, digit accumulator and result register.
    lcc_datapath u_datapath (
        .i_clk          (i_clk),
        .i_cmd          (dp_cmd),
        .i_card_number  (i_card_number),
        .o_sts          (dp_sts),
        .o_status       (o_status),
        .o_luhn_sum     (o_luhn_sum),
        .o_digit_count  (o_digit_count),
        .o_leading_pair (o_leading_pair)
    );

endmodule

@@ tb/luhn_result_checker.sv @@
// Predicts each card check result and compares it with the result beats of the block.
`timescale 1ns / 100ps

module luhn_result_checker
    import lcc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_card_valid,
    input  logic                i_card_ready,
    input  logic [NUM_W-1:0]    i_card_number,
    input  logic                i_res_valid,
    input  logic                i_res_ready,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [SUM_W-1:0]    i_luhn_sum,
    input  logic [COUNT_W-1:0]  i_digit_count,
    input  logic [PAIR_W-1:0]   i_leading_pair,
    output int                  o_fail_count,
    output int                  o_pending
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SUM_W-1:0]    luhn_sum;
        logic [COUNT_W-1:0]  digit_count;
        logic [PAIR_W-1:0]   leading_pair;
    } t_luhn_result;

    t_luhn_result expected_results [$];
    t_luhn_result oldest;
    int           fail_count = 0;
    int           pending    = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    // Peel decimal digits from the right, double every second one, then classify.
    function automatic t_luhn_result compute_luhn_result(input logic [NUM_W-1:0] card);
        logic [NUM_W-1:0] rest;
        int unsigned      digit;
        int unsigned      doubled;
        int unsigned      sum;
        int unsigned      count;
        int unsigned      lead_digit;
        int unsigned      next_digit;
        int unsigned      pair;
        t_luhn_result     r;
        rest       = card;
        sum        = 0;
        count      = 0;
        lead_digit = 0;
        next_digit = 0;
        pair       = 0;
        while (rest != 0) begin
            digit = int'(rest % 64'd10);
            count++;
            if (count % 2 == 0) begin
                doubled = digit * 2;
                sum += doubled / 10 + doubled % 10;
            end else begin
                sum += digit;
            end
            next_digit = lead_digit;
            lead_digit = digit;
            rest       = rest / 64'd10;
        end
        if (sum % 10 != 0) begin
            r.status = STATUS_SUM_FAIL;
        end else if (count != LEN_13 && count != LEN_15 && count != LEN_16) begin
            r.status = STATUS_BAD_LENGTH;
        end else begin
            pair = lead_digit * 10 + next_digit;
            if (pair == PAIR_34 || pair == PAIR_37) begin
                r.status = STATUS_PAIR_34_37;
            end else if (pair >= PAIR_51 && pair <= PAIR_55) begin
                r.status = STATUS_PAIR_51_55;
            end else if (lead_digit == LEAD_FOUR) begin
                r.status = STATUS_LEAD_FOUR;
            end else begin
                r.status = STATUS_UNKNOWN;
            end
        end
        r.luhn_sum     = SUM_W'(sum);
        r.digit_count  = COUNT_W'(count);
        r.leading_pair = PAIR_W'(pair);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no card waiting: status %0d sum %0d",
                           i_status, i_luhn_sum);
                    fail_count++;
                end else begin
                    oldest = expected_results.pop_front();
                    pending--;
                    if (i_status !== oldest.status) begin
                        $error("status: expected %0d, actual %0d", oldest.status, i_status);
                        fail_count++;
                    end
                    if (i_luhn_sum !== oldest.luhn_sum) begin
                        $error("luhn_sum: expected %0d, actual %0d",
                               oldest.luhn_sum, i_luhn_sum);
                        fail_count++;
                    end
                    if (i_digit_count !== oldest.digit_count) begin
                        $error("digit_count: expected %0d, actual %0d",
                               oldest.digit_count, i_digit_count);
                        fail_count++;
                    end
                    if (i_leading_pair !== oldest.leading_pair) begin
                        $error("leading_pair: expected %0d, actual %0d",
                               oldest.leading_pair, i_leading_pair);
                        fail_count++;
                    end
                end
            end
            if (i_card_valid && i_card_ready) begin
                expected_results.push_back(compute_luhn_result(i_card_number));
                pending++;
            end
        end
    end

endmodule

@@ tb/luhn_card_number_check_test.sv @@
// Top of the card number check test: clock, reset, card stimulus, result back-pressure, verdict.
`timescale 1ns / 100ps

module luhn_card_number_check_test
    import lcc_pkg::*;
();

    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 400;
    localparam int CALM_TAIL    = 60;    // last random items run with no idling
    localparam int PAUSE_AT     = 200;   // random item before which the sender drains
    localparam int HOLD_AFTER   = 120;   // card beats before the long receiver hold
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int QUIET_LIMIT  = 5000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_card_valid;
    logic                o_card_ready;
    logic [NUM_W-1:0]    i_card_number;
    logic                o_res_valid;
    logic                i_res_ready;
    logic [STATUS_W-1:0] o_status;
    logic [SUM_W-1:0]    o_luhn_sum;
    logic [COUNT_W-1:0]  o_digit_count;
    logic [PAIR_W-1:0]   o_leading_pair;

    int check_failures;
    int pending_results;
    int cards_accepted = 0;
    bit idle_enable    = 1'b1;

    wire card_beat   = i_card_valid && o_card_ready;
    wire result_beat = o_res_valid && i_res_ready;

    luhn_card_number_check DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_card_valid   (i_card_valid),
        .o_card_ready   (o_card_ready),
        .i_card_number  (i_card_number),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_status       (o_status),
        .o_luhn_sum     (o_luhn_sum),
        .o_digit_count  (o_digit_count),
        .o_leading_pair (o_leading_pair)
    );

    // Watch both channels, predict each card's result and compare.
    luhn_result_checker result_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_card_valid   (i_card_valid),
        .i_card_ready   (o_card_ready),
        .i_card_number  (i_card_number),
        .i_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .i_status       (o_status),
        .i_luhn_sum     (o_luhn_sum),
        .i_digit_count  (o_digit_count),
        .i_leading_pair (o_leading_pair),
        .o_fail_count   (check_failures),
        .o_pending      (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Count card beats so the receiver knows when to start its long hold.
    always @(posedge i_clk) begin
        if (i_rst_n && card_beat) begin
            cards_accepted <= cards_accepted + 1;
        end
    end

    // Build a card number of the given length with a one- or two-digit lead,
    // random middle digits and a check digit that makes the Luhn sum pass,
    // or deliberately miss it when luhn_ok is clear. Length is 3 to 19.
    function automatic logic [NUM_W-1:0] build_card_number(input int unsigned lead,
                                                           input int unsigned lead_len,
                                                           input int unsigned len,
                                                           input bit luhn_ok);
        int unsigned      digit_at [20];
        int unsigned      weighted;
        int unsigned      sum;
        int unsigned      check;
        logic [NUM_W-1:0] value;
        sum = 0;
        for (int i = 0; i < len - 1; i++) begin
            digit_at[i] = $urandom_range(9);
        end
        if (lead_len == 2) begin
            digit_at[0] = lead / 10;
            digit_at[1] = lead % 10;
        end else begin
            digit_at[0] = lead;
        end
        // The check digit sits at position one from the right, so the
        // payload digit at index i sits at position len - i.
        for (int i = 0; i < len - 1; i++) begin
            if ((len - i) % 2 == 0) begin
                weighted = digit_at[i] * 2;
                sum += weighted / 10 + weighted % 10;
            end else begin
                sum += digit_at[i];
            end
        end
        check = (10 - sum % 10) % 10;
        if (!luhn_ok) begin
            check = (check + $urandom_range(1, 9)) % 10;
        end
        digit_at[len - 1] = check;
        value = '0;
        for (int i = 0; i < len; i++) begin
            value = value * 64'd10 + NUM_W'(digit_at[i]);
        end
        return value;
    endfunction

    // Offer one card beat, starting and ending at a falling edge. Drop valid
    // for a random burst first when idling is on; otherwise keep it high so
    // back-to-back beats go out with no bubble.
    task automatic send_card(input logic [NUM_W-1:0] value);
        int unsigned gap;
        if (idle_enable && $urandom_range(99) < 20) begin
            gap = $urandom_range(1, 19);
            i_card_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_card_valid  <= 1'b1;
        i_card_number <= value;
        forever begin
            @(posedge i_clk);
            if (o_card_ready) break;
        end
        @(negedge i_clk);
    endtask

    // Receiver: ready high by default, random low bursts, and one long hold
    // once enough cards went in, so the block fills and stalls its input.
    initial begin : result_sink
        int unsigned gap;
        bit          long_hold_done;
        long_hold_done = 1'b0;
        i_res_ready    = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && cards_accepted >= HOLD_AFTER) begin
                i_res_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold_done = 1'b1;
                i_res_ready <= 1'b1;
            end else if (idle_enable && $urandom_range(99) < 15) begin
                gap = $urandom_range(1, 19);
                i_res_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
                i_res_ready <= 1'b1;
            end else begin
                i_res_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no beat moves on either channel for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        wait (i_rst_n);
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (card_beat || result_beat) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[luhn_card_number_check] ERROR");
        $finish;
    end

    // Stimulus and verdict.
    initial begin : card_source
        int unsigned      lead;
        int unsigned      lead_len;
        int unsigned      len;
        int unsigned      pick;
        logic [NUM_W-1:0] card;
        i_rst_n       = 1'b0;
        i_card_valid  = 1'b0;
        i_card_number = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: zero (no digits), tiny values, the 20-digit extremes,
        // every prefix class with its neighbors, lengths just off 13/15/16,
        // and Luhn misses on otherwise good numbers.
        send_card('0);
        send_card(64'd1);
        send_card(64'd9);
        send_card({NUM_W{1'b1}});
        send_card(64'd10000000000000000000);
        send_card(64'd9999999999999999);
        send_card(build_card_number(PAIR_34, 2, LEN_15, 1'b1));
        send_card(build_card_number(PAIR_37, 2, LEN_15, 1'b1));
        send_card(build_card_number(33, 2, LEN_15, 1'b1));
        send_card(build_card_number(38, 2, LEN_15, 1'b1));
        send_card(build_card_number(PAIR_51, 2, LEN_16, 1'b1));
        send_card(build_card_number(PAIR_55, 2, LEN_16, 1'b1));
        send_card(build_card_number(50, 2, LEN_16, 1'b1));
        send_card(build_card_number(56, 2, LEN_16, 1'b1));
        send_card(build_card_number(LEAD_FOUR, 1, LEN_13, 1'b1));
        send_card(build_card_number(40, 2, LEN_16, 1'b1));
        send_card(build_card_number(49, 2, LEN_15, 1'b1));
        send_card(build_card_number(60, 2, LEN_16, 1'b1));
        send_card(build_card_number(PAIR_34, 2, 14, 1'b1));
        send_card(build_card_number(LEAD_FOUR, 1, 12, 1'b1));
        send_card(build_card_number(LEAD_FOUR, 1, 17, 1'b1));
        send_card(build_card_number(PAIR_37, 2, LEN_15, 1'b0));
        send_card(build_card_number(LEAD_FOUR, 1, LEN_16, 1'b0));

        // Random: mostly well-formed card numbers, some odd lengths, some noise.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - CALM_TAIL) begin
                idle_enable = 1'b0;
            end
            if (n == PAUSE_AT) begin
                // Hold off until every outstanding result is back.
                i_card_valid <= 1'b0;
                @(negedge i_clk);
                while (pending_results != 0) @(negedge i_clk);
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                lead_len = 2;
                case ($urandom_range(4))
                    0: lead = $urandom_range(1) ? PAIR_34 : PAIR_37;
                    1: lead = PAIR_51 + $urandom_range(4);
                    2: begin
                        lead     = LEAD_FOUR;
                        lead_len = 1;
                    end
                    3: lead = $urandom_range(40, 49);
                    default: lead = $urandom_range(10, 99);
                endcase
                case ($urandom_range(2))
                    0: len = LEN_13;
                    1: len = LEN_15;
                    default: len = LEN_16;
                endcase
                card = build_card_number(lead, lead_len, len, $urandom_range(9) != 0);
            end else if (pick < 85) begin
                card = build_card_number($urandom_range(10, 99), 2, $urandom_range(3, 19),
                                         $urandom_range(3) != 0);
            end else begin
                case ($urandom_range(2))
                    0: card = {$urandom, $urandom};
                    1: card = NUM_W'($urandom_range(0, 9999));
                    default: card = {NUM_W{1'b1}} - NUM_W'($urandom_range(0, 1000));
                endcase
            end
            send_card(card);
        end
        i_card_valid <= 1'b0;

        // Drain: wait for every result, then give stray beats time to show.
        while (pending_results != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (check_failures == 0 && pending_results == 0) begin
            $display("[luhn_card_number_check] OK");
        end else begin
            $display("[luhn_card_number_check] ERROR");
        end
        $finish;
    end

endmodule
